// File: design/bptt_pkg.sv
`timescale 1ns / 1ps

package bptt_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // Slot compares run at the wider of the index width and the port's slot field.
    localparam int CMP_W  = (SLOT_W > 6) ? SLOT_W : 6;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CNTX_W = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_EVICT  = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_DIRTY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    // Request token that walks the cell chain, collecting the scan results.
    typedef struct packed {
        logic              vld;
        t_op               op;
        logic [15:0]       fid;
        logic [31:0]       boff;
        logic [5:0]        slot;
        logic              found;
        logic [SLOT_W-1:0] pick;
        logic              pick_valid;
        logic              inv_found;
        logic [SLOT_W-1:0] inv_idx;
        logic [CNT_W-1:0]  count;
        logic              wb;
    } t_token;

    // Fill broadcast to all cells once a lookup has chosen its slot.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [15:0]       fid;
        logic [31:0]       boff;
    } t_fill;

endpackage

// File: design/bptt_cell.sv
`timescale 1ns / 1ps

module bptt_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [bptt_pkg::SLOT_W-1:0] i_idx,
    input  bptt_pkg::t_token       i_tok,
    input  bptt_pkg::t_fill        i_fill,
    output bptt_pkg::t_token       o_tok
);
    import bptt_pkg::*;

    logic [15:0] r_file, n_file;
    logic [31:0] r_off,  n_off;
    logic        r_asg,  n_asg;
    logic        r_vld,  n_vld;
    logic        r_dty,  n_dty;
    t_token      r_tok,  n_tok;

    logic tag_hit;
    logic file_hit;
    logic slot_sel;

    assign file_hit = (r_file == i_tok.fid);
    assign tag_hit  = r_asg && file_hit && (r_off == i_tok.boff);
    assign slot_sel = (CMP_W'(i_tok.slot) == CMP_W'(i_idx));

    always_comb begin
        n_tok  = i_tok;
        n_file = r_file;
        n_off  = r_off;
        n_asg  = r_asg;
        n_vld  = r_vld;
        n_dty  = r_dty;

        if (i_tok.vld) begin
            case (i_tok.op)
                OP_LOOKUP: begin
                    // first match wins, last invalid slot is the fallback
                    if (!i_tok.found && tag_hit) begin
                        n_tok.found      = 1'b1;
                        n_tok.pick       = i_idx;
                        n_tok.pick_valid = r_vld;
                    end
                    if (!r_vld) begin
                        n_tok.inv_found = 1'b1;
                        n_tok.inv_idx   = i_idx;
                    end
                end
                OP_EVICT: begin
                    if (slot_sel) begin
                        n_tok.wb = r_dty;
                        n_vld    = 1'b0;
                    end
                end
                OP_FLUSH: begin
                    if (r_vld && file_hit) begin
                        n_vld       = 1'b0;
                        n_tok.count = i_tok.count + CNT_W'(1);
                    end
                end
                OP_DIRTY: begin
                    if (slot_sel) begin
                        n_dty = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_fill.en && (i_fill.idx == i_idx)) begin
            n_file = i_fill.fid;
            n_off  = i_fill.boff;
            n_asg  = 1'b1;
            n_vld  = 1'b1;
            n_dty  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_file <= n_file;
        r_off  <= n_off;
        if (!i_rst_n) begin
            r_asg     <= 1'b0;
            r_vld     <= 1'b0;
            r_dty     <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_asg <= n_asg;
            r_vld <= n_vld;
            r_dty <= n_dty;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: design/buffer_pool_tag_table_unit.sv
`timescale 1ns / 1ps

// Tag table of a fully associative buffer pool with SLOTS slots (64 here).
// Every request (lookup and fill, evict, flush file, mark dirty) gives one
// result. The table works on one request at a time: a request enters a chain
// of SLOTS cells, one slot per cell, and moves one cell per clock, so each
// cell compares and updates its own slot as the request passes. A request
// is taken only once the previous one has left the chain and its result has
// reached the output register; a lookup's fill is written in the clock
// the request leaves the chain. A finished result sits in the output register
// while the next request is accepted. There is no clearing pass after reset.
module buffer_pool_tag_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] file_id, [47:16] block_offset, [53:48] slot, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] chosen_slot, [6] hit, [7] needs_load, [8] write_back,
    // [15:9] flushed_count
    output logic [15:0] m_axis_tdata
);
    import bptt_pkg::*;

    t_state r_state, n_state;

    t_token r_inj, n_inj;
    t_token w_tok [SLOTS+1];
    t_token w_exit;
    t_fill  w_fill;

    logic        r_m_valid;
    logic [15:0] r_m_data;
    logic [15:0] r_pend;

    logic              w_accept;
    logic              w_out_free;
    logic              w_ld_out;
    logic              w_ld_pend;
    logic              w_from_pend;
    logic [SLOT_W-1:0] w_pick;
    logic              w_load;
    logic [CMP_W-1:0]  w_pick_x;
    logic [CNTX_W-1:0] w_cnt_x;
    logic [15:0]       w_res;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_exit     = w_tok[SLOTS];

    // Build the token for a new request: all scan results start cleared.
    always_comb begin
        n_inj            = '0;
        n_inj.vld        = w_accept;
        n_inj.op         = t_op'(s_axis_tuser);
        n_inj.fid        = s_axis_tdata[15:0];
        n_inj.boff       = s_axis_tdata[47:16];
        n_inj.slot       = s_axis_tdata[53:48];
    end

    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        bptt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_tok   (w_tok[g]),
            .i_fill  (w_fill),
            .o_tok   (w_tok[g+1])
        );
    end

    // Resolve the lookup once the token has seen every slot: a tag match
    // first, then the highest free slot, else slot 0 with nothing changed.
    always_comb begin
        if (w_exit.found) begin
            w_pick = w_exit.pick;
            w_load = !w_exit.pick_valid;
        end else if (w_exit.inv_found) begin
            w_pick = w_exit.inv_idx;
            w_load = 1'b1;
        end else begin
            w_pick = '0;
            w_load = 1'b0;
        end
    end

    assign w_fill.en   = w_exit.vld && (w_exit.op == OP_LOOKUP) && w_load;
    assign w_fill.idx  = w_pick;
    assign w_fill.fid  = w_exit.fid;
    assign w_fill.boff = w_exit.boff;

    assign w_pick_x = CMP_W'(w_pick);
    assign w_cnt_x  = CNTX_W'(w_exit.count);

    // Drop the fields that do not belong to the request's op.
    always_comb begin
        w_res = '0;
        case (w_exit.op)
            OP_LOOKUP: begin
                w_res[5:0] = w_pick_x[5:0];
                w_res[6]   = w_exit.found;
                w_res[7]   = w_load;
            end
            OP_EVICT: begin
                w_res[8] = w_exit.wb;
            end
            OP_FLUSH: begin
                w_res[15:9] = w_cnt_x[6:0];
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_exit.vld) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        w_ld_out      = 1'b0;
        w_ld_pend     = 1'b0;
        w_from_pend   = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_SCAN: begin
                w_ld_out  = w_exit.vld && w_out_free;
                w_ld_pend = w_exit.vld && !w_out_free;
            end
            S_HOLD: begin
                w_ld_out    = w_out_free;
                w_from_pend = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_pend) begin
            r_pend <= w_res;
        end
        if (w_ld_out) begin
            r_m_data <= w_from_pend ? r_pend : w_res;
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_inj.vld <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj   <= n_inj;
            if (w_ld_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
